// ----- src/median_predict_and_histogram_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the median predictor and residual histogram
// Checks are compiled in for simulation and drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_PREDICT_AND_HISTOGRAM_TOP_DEFINES_SVH
`define MEDIAN_PREDICT_AND_HISTOGRAM_TOP_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define MPH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on every clock edge, reset included.
`define MPH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MPH_ASSERT(lbl, prop, msg)
`define MPH_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/mph_pkg.sv -----
// ----------------------------------------------------------------------------
// mph_pkg
// Shared constants, codes and request types of the median predictor.
// ----------------------------------------------------------------------------
package mph_pkg;

  localparam int MAX_STRIDE = 4096;
  localparam int LINE_DEPTH = MAX_STRIDE + 1;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int POS_W      = $clog2(LINE_DEPTH + 1);

  localparam int STRIDE_W = 13;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1920;

  localparam logic [7:0] MID_VALUE = 8'h80;

  // Request action codes
  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_FRAME = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PIXEL,
    OP_READ
  } op_t;

  typedef enum logic [1:0] {
    PK_LEFT,
    PK_ROW2,
    PK_MEDIAN
  } pred_kind_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pixel;
    logic [7:0] bin_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  residual;
    logic [31:0] bin_count;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    op_t        op;
    pred_kind_t kind;
    logic [7:0] pixel;
    logic [7:0] left;
    logic [7:0] bin_index;
  } pix_stage_t;

  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] residual;
    logic [7:0] addr;
  } hist_req_t;

endpackage

// ----- src/mph_front.sv -----
// ----------------------------------------------------------------------------
// mph_front
// Line store and raster position tracking; issues top and top-left reads.
// ----------------------------------------------------------------------------
`include "median_predict_and_histogram_top_defines.svh"

module mph_front import mph_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  in_item_t            in_data,
  input  logic [STRIDE_W-1:0] row_stride,
  output pix_stage_t          s1,
  output logic [7:0]          top_q,
  output logic [7:0]          tl_q
);

  localparam logic [LINE_AW:0] LD_EXT = (LINE_AW + 1)'(LINE_DEPTH);

  logic [7:0]         line_mem [LINE_DEPTH];

  logic [LINE_AW-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [7:0]         left_r, left_nxt;
  pix_stage_t         s1_r, s1_nxt;
  logic [7:0]         top_q_r, tl_q_r;

  logic [31:0]        stride32;
  logic [LINE_AW-1:0] stride_eff;
  logic               is_pix;
  logic               is_frame;
  logic               pix_wr;
  logic [POS_W-1:0]   pos_cur;
  logic [7:0]         left_cur;
  logic [LINE_AW:0]   top_sum, tl_sum;
  logic [LINE_AW-1:0] top_addr, tl_addr;
  op_t                op;

  always_comb begin
    stride32 = 32'(row_stride);
    if (stride32 == 32'd0) begin
      stride_eff = LINE_AW'(1);
    end else if (stride32 > 32'(MAX_STRIDE)) begin
      stride_eff = LINE_AW'(MAX_STRIDE);
    end else begin
      stride_eff = LINE_AW'(stride32);
    end
  end

  always_comb begin
    case (in_data.action)
      ACT_PIXEL: begin
        op       = OP_PIXEL;
        is_frame = 1'b0;
      end
      ACT_FRAME: begin
        op       = OP_PIXEL;
        is_frame = 1'b1;
      end
      ACT_READ: begin
        op       = OP_READ;
        is_frame = 1'b0;
      end
      default: begin
        op       = OP_NONE;
        is_frame = 1'b0;
      end
    endcase
    is_pix = in_valid && (op == OP_PIXEL);
    pix_wr = en && is_pix;
  end

  always_comb begin
    pos_cur  = is_frame ? '0 : pos_r;
    left_cur = is_frame ? MID_VALUE : left_r;

    // circular distance back from the write pointer, one wrap at most
    top_sum  = {1'b0, wp_r} + LD_EXT - {1'b0, stride_eff};
    tl_sum   = top_sum - (LINE_AW + 1)'(1);
    top_addr = (top_sum >= LD_EXT) ? LINE_AW'(top_sum - LD_EXT) : LINE_AW'(top_sum);
    tl_addr  = (tl_sum >= LD_EXT) ? LINE_AW'(tl_sum - LD_EXT) : LINE_AW'(tl_sum);

    s1_nxt.valid     = in_valid;
    s1_nxt.op        = op;
    s1_nxt.pixel     = in_data.pixel;
    s1_nxt.left      = left_cur;
    s1_nxt.bin_index = in_data.bin_index;
    if (32'(pos_cur) < 32'(stride_eff)) begin
      s1_nxt.kind = PK_LEFT;
    end else if (32'(pos_cur) == 32'(stride_eff)) begin
      s1_nxt.kind = PK_ROW2;
    end else begin
      s1_nxt.kind = PK_MEDIAN;
    end

    wp_nxt   = (32'(wp_r) == LINE_DEPTH - 1) ? '0 : wp_r + LINE_AW'(1);
    pos_nxt  = (32'(pos_cur) < 32'(LINE_DEPTH)) ? pos_cur + POS_W'(1) : pos_cur;
    left_nxt = in_data.pixel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      pos_r  <= '0;
      left_r <= MID_VALUE;
      s1_r   <= '0;
    end else if (en) begin
      s1_r <= s1_nxt;
      if (pix_wr) begin
        wp_r   <= wp_nxt;
        pos_r  <= pos_nxt;
        left_r <= left_nxt;
      end
    end
  end

  // read-first: a top-left read of the entry being written sees the old pixel
  always_ff @(posedge clk) begin
    if (pix_wr) begin
      line_mem[wp_r] <= in_data.pixel;
    end
    if (pix_wr) begin
      top_q_r <= line_mem[top_addr];
      tl_q_r  <= line_mem[tl_addr];
    end
  end

  assign s1    = s1_r;
  assign top_q = top_q_r;
  assign tl_q  = tl_q_r;

  `MPH_ASSERT(a_wp_range, 32'(wp_r) < LINE_DEPTH, "line store write pointer out of range")
  `MPH_ASSERT(a_pos_sat, 32'(pos_r) <= LINE_DEPTH, "pixel position above saturation")

endmodule

// ----- src/mph_predict.sv -----
// ----------------------------------------------------------------------------
// mph_predict
// Median prediction and residual; forms the histogram request.
// ----------------------------------------------------------------------------
module mph_predict import mph_pkg::*; (
  input  pix_stage_t s1,
  input  logic [7:0] top_q,
  input  logic [7:0] tl_q,
  output hist_req_t  req
);

  logic [7:0] left_eff, tl_eff, grad;
  logic [7:0] mx_ab, mn_ab, mn_c, med, pred, residual;

  always_comb begin
    // first pixel of row two: left and top-left act as mid-gray
    left_eff = (s1.kind == PK_ROW2) ? MID_VALUE : s1.left;
    tl_eff   = (s1.kind == PK_ROW2) ? MID_VALUE : tl_q;
    grad     = left_eff + top_q - tl_eff;

    mx_ab = (left_eff > top_q) ? left_eff : top_q;
    mn_ab = (left_eff < top_q) ? left_eff : top_q;
    mn_c  = (mx_ab < grad) ? mx_ab : grad;
    med   = (mn_c > mn_ab) ? mn_c : mn_ab;

    pred     = (s1.kind == PK_LEFT) ? s1.left : med;
    residual = s1.pixel - pred;

    req.valid    = s1.valid;
    req.op       = s1.op;
    req.residual = residual;
    req.addr     = (s1.op == OP_READ) ? s1.bin_index : residual;
  end

endmodule

// ----- src/mph_hist.sv -----
// ----------------------------------------------------------------------------
// mph_hist
// Residual histogram: read, saturating increment or clear, write back.
// ----------------------------------------------------------------------------
`include "median_predict_and_histogram_top_defines.svh"

module mph_hist import mph_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  hist_req_t req,
  output logic      s2_valid,
  output out_item_t s2_item
);

  logic [31:0]  hist_mem [256];
  logic [255:0] bin_vld_r;

  logic         s2_valid_r;
  op_t          s2_op_r;
  logic [7:0]   s2_res_r;
  logic [7:0]   s2_addr_r;
  logic [31:0]  q_r;
  logic         qv_r;
  logic         fwd_r;
  logic [31:0]  fwd_data_r;

  logic         rd_en;
  logic [31:0]  cur;
  logic         wr_en;
  logic [31:0]  wr_data;
  logic         hit;

  always_comb begin
    rd_en = req.valid && (req.op != OP_NONE);
    // newest value: bypass a write that landed on the bin as it was read
    if (fwd_r) begin
      cur = fwd_data_r;
    end else if (qv_r) begin
      cur = q_r;
    end else begin
      cur = '0;
    end
    wr_en   = en && s2_valid_r && (s2_op_r != OP_NONE);
    wr_data = (s2_op_r == OP_READ) ? '0 :
              ((cur == '1) ? cur : cur + 32'd1);
    hit     = wr_en && rd_en && (s2_addr_r == req.addr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_vld_r  <= '0;
      s2_valid_r <= 1'b0;
      s2_op_r    <= OP_NONE;
      fwd_r      <= 1'b0;
    end else if (en) begin
      s2_valid_r <= req.valid;
      s2_op_r    <= req.op;
      if (rd_en) begin
        fwd_r <= hit;
      end
      if (wr_en) begin
        bin_vld_r[s2_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_res_r   <= req.residual;
      s2_addr_r  <= req.addr;
      fwd_data_r <= wr_data;
    end
    if (wr_en) begin
      hist_mem[s2_addr_r] <= wr_data;
    end
    if (en && rd_en) begin
      q_r  <= hist_mem[req.addr];
      qv_r <= bin_vld_r[req.addr];
    end
  end

  assign s2_valid           = s2_valid_r;
  assign s2_item.residual   = (s2_op_r == OP_PIXEL) ? s2_res_r : 8'd0;
  assign s2_item.bin_count  = (s2_op_r == OP_READ) ? cur : 32'd0;

  `MPH_ASSERT(a_no_wrap, s2_valid_r && s2_op_r == OP_PIXEL |-> wr_data != 32'd0, "bin count wrapped")
  `MPH_ASSERT(a_fwd_hit, hit |=> fwd_r, "missed bypass on back-to-back bin access")

endmodule

// ----- src/median_predict_and_histogram_top.sv -----
// ----------------------------------------------------------------------------
// median_predict_and_histogram_top
// Median predictor for one 8-bit plane with a 256-bin residual histogram.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one request: action 0 codes the next pixel, action 1 codes
//   the first pixel of a new frame, action 2 reads one histogram bin and
//   clears it. Each request gives exactly one out_data item (residual for
//   pixels, bin_count for reads, zeros otherwise).
//   cfg_data writes row_stride; cfg_ready is always high. Write it only while
//   no request is in flight.
//   A taken request passes the line-store read, the histogram read and the
//   output register before out_valid rises for it. Throughput: one
//   request per cycle unless a stall holds it; the histogram read-modify-write
//   runs once per cycle, bypassing the same bin on consecutive requests.
//   Stall: while out_valid is high and out_stall is high, the whole pipeline
//   holds and in_stall is raised; bubbles are filled otherwise.
//   Reset: histogram bins read as zero, stride is 1920, the stream starts as
//   at a frame start. The line store needs no clearing.
// ----------------------------------------------------------------------------
module median_predict_and_histogram_top import mph_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STRIDE_W-1:0] cfg_data
);

  logic [STRIDE_W-1:0] row_stride_r;
  logic                out_valid_r;
  out_item_t           out_data_r;
  logic                en;
  pix_stage_t          s1;
  logic [7:0]          top_q, tl_q;
  hist_req_t           req;
  logic                s2_valid;
  out_item_t           s2_item;

  // advance whenever the output register is free or being drained
  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      row_stride_r <= cfg_data;
    end
  end

  mph_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .row_stride (row_stride_r),
    .s1         (s1),
    .top_q      (top_q),
    .tl_q       (tl_q)
  );

  mph_predict u_predict (
    .s1    (s1),
    .top_q (top_q),
    .tl_q  (tl_q),
    .req   (req)
  );

  mph_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .req      (req),
    .s2_valid (s2_valid),
    .s2_item  (s2_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= s2_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
